[hw/rtl/bd_pkg.sv]
// Shared types and constants for the bounded deque.
package bd_pkg;

  // Built depth of the cell chain
  localparam int DEPTH = 16;
  localparam int VAL_W = 32;
  localparam int CAP_W = 5;
  localparam int OUT_CNT_W = 5;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);
  localparam logic [VAL_W-1:0] INT_MIN = {1'b1, {(VAL_W-1){1'b0}}};

  typedef logic [VAL_W-1:0] word_t;

  typedef enum logic [1:0] {
    CMD_PUSH_FRONT = 2'd0,
    CMD_PUSH_REAR  = 2'd1,
    CMD_POP_FRONT  = 2'd2,
    CMD_POP_REAR   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  // Per-cell control: shift toward rear, shift toward front, load push word
  typedef struct packed {
    logic shr;
    logic shl;
    logic wr;
  } cell_ctl_t;

endpackage

[hw/rtl/bd_cell.sv]
// One storage cell of the deque chain; trades its word with its neighbors.
module bd_cell (
  input  logic             clk,
  input  bd_pkg::cell_ctl_t ctl,
  input  bd_pkg::word_t    left_d,   // neighbor toward the front
  input  bd_pkg::word_t    right_d,  // neighbor toward the rear
  input  bd_pkg::word_t    push_d,
  output bd_pkg::word_t    q
);
  import bd_pkg::*;

  word_t data_r;
  word_t data_nxt;

  // Load, shift or hold
  always_comb begin
    data_nxt = data_r;
    if (ctl.wr) begin
      data_nxt = push_d;
    end else if (ctl.shr) begin
      data_nxt = left_d;
    end else if (ctl.shl) begin
      data_nxt = right_d;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign q = data_r;

endmodule

[hw/rtl/bounded_deque.sv]
// Top level of the bounded deque: cell chain, count, capacity and result register.
//
// Usage:
//   in_*   : one command word per handshake. in_tuser carries the command
//            (push front, push rear, pop front, pop rear), in_tdata the word
//            to push (ignored by pops).
//   out_*  : exactly one result word per command, in order. out_tdata holds
//            the popped word and the count after the command; out_tuser the
//            status (done, full, empty) and the empty flag.
//   cfg_*  : writes the capacity register; always ready. Write only while idle.
// Storage is a chain of DEPTH cells with the front entry in cell 0. A push
// at the front shifts the chain toward the rear, a pop at the front shifts
// it back; rear pushes load the cell at the count, rear pops read cell count - 1.
// The result is registered and valid in the cycle after the command is taken.
// Throughput: one command per cycle while out_tready is high; each command
// updates the chain and the count in the cycle it is accepted.
// Reset empties the deque and sets the capacity to 16. Cell contents are
// not cleared: the count makes unwritten cells unreachable.
// If the receiver stalls, the result is held and in_tready drops until it
// is taken; with out_tready high a new command is taken every cycle.
module bounded_deque (
  input  logic        clk,
  input  logic        rst_n,
  // in_tdata: [31:0] push_value
  input  logic [31:0] in_tdata,
  // in_tuser: [1:0] command
  input  logic [1:0]  in_tuser,
  input  logic        in_tvalid,
  output logic        in_tready,
  // out_tdata: [31:0] pop_value, [36:32] entry_count, [39:37] zero
  output logic [39:0] out_tdata,
  // out_tuser: [1:0] status, [2] is_empty
  output logic [2:0]  out_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  input  logic [bd_pkg::CAP_W-1:0] cfg_data,
  input  logic        cfg_valid,
  output logic        cfg_ready
);
  import bd_pkg::*;

  logic [CAP_W-1:0] capacity_r;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [CNT_W-1:0] eff_cap;
  logic             out_valid_r, out_valid_nxt;
  word_t            pop_r, pop_nxt;
  status_t          status_r, status_nxt;
  logic [CNT_W-1:0] res_cnt_r;
  logic             accept, full, empty, is_push, push_ok, pop_ok;
  logic [IDX_W-1:0] rear_idx;
  cmd_t             cmd;
  word_t            push_word;
  word_t            cell_q [DEPTH];
  cell_ctl_t        cell_ctl [DEPTH];

  assign cmd       = cmd_t'(in_tuser);
  assign push_word = in_tdata;
  assign in_tready = !out_valid_r || out_tready;
  assign accept    = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  // Capacity register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      capacity_r <= CAP_RESET;
    end else if (cfg_valid) begin
      capacity_r <= cfg_data;
    end
  end

  // Capacity saturated to the built depth
  always_comb begin
    if (32'(capacity_r) > 32'(DEPTH)) begin
      eff_cap = CNT_W'(DEPTH);
    end else begin
      eff_cap = CNT_W'(capacity_r);
    end
  end

  assign full     = count_r >= eff_cap;
  assign empty    = count_r == '0;
  assign is_push  = (cmd == CMD_PUSH_FRONT) || (cmd == CMD_PUSH_REAR);
  assign push_ok  = accept && is_push && !full;
  assign pop_ok   = accept && !is_push && !empty;
  assign rear_idx = IDX_W'(count_r - CNT_W'(1));

  // Cell chain
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    word_t left_d, right_d;
    if (i == 0) begin : g_head
      assign left_d = push_word;
    end else begin : g_mid
      assign left_d = cell_q[i-1];
    end
    if (i == DEPTH - 1) begin : g_tail
      assign right_d = '0;
    end else begin : g_body
      assign right_d = cell_q[i+1];
    end

    assign cell_ctl[i].shr = push_ok && (cmd == CMD_PUSH_FRONT);
    assign cell_ctl[i].shl = pop_ok && (cmd == CMD_POP_FRONT);
    assign cell_ctl[i].wr  = push_ok && (cmd == CMD_PUSH_REAR) && (count_r == CNT_W'(i));

    bd_cell u_cell (
      .clk     (clk),
      .ctl     (cell_ctl[i]),
      .left_d  (left_d),
      .right_d (right_d),
      .push_d  (push_word),
      .q       (cell_q[i])
    );
  end

  // Count and result
  always_comb begin
    count_nxt  = count_r;
    pop_nxt    = pop_r;
    status_nxt = status_r;
    if (accept) begin
      status_nxt = ST_DONE;
      pop_nxt    = '0;
      if (is_push) begin
        if (full) begin
          status_nxt = ST_FULL;
        end else begin
          count_nxt = count_r + CNT_W'(1);
        end
      end else if (empty) begin
        status_nxt = ST_EMPTY;
        pop_nxt    = INT_MIN;
      end else begin
        count_nxt = count_r - CNT_W'(1);
        if (cmd == CMD_POP_FRONT) begin
          pop_nxt = cell_q[0];
        end else begin
          pop_nxt = cell_q[rear_idx];
        end
      end
    end
  end

  assign out_valid_nxt = accept ? 1'b1 : (out_tready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    pop_r    <= pop_nxt;
    status_r <= status_nxt;
    if (accept) begin
      res_cnt_r <= count_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, OUT_CNT_W'(res_cnt_r), pop_r};
  assign out_tuser  = {res_cnt_r == '0, status_r};

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(count_r) <= 32'(DEPTH))
    else $error("count exceeds depth");

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_tvalid)
    else $error("accepted command produced no result");

  a_empty_pop: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && !is_push && empty) |=> (out_tuser[1:0] == ST_EMPTY && out_tdata[31:0] == INT_MIN))
    else $error("empty pop not reported");

  a_push_count: assert property (@(posedge clk) disable iff (!rst_n)
    push_ok |=> (count_r == $past(count_r) + CNT_W'(1)))
    else $error("push did not advance count");
`endif

endmodule
